@@ rtl/pfa_pkg.sv @@
// shared types and codes for the page frame allocator
package pfa_pkg;

  localparam int unsigned FRAME_W  = 16;
  localparam int unsigned COUNT_W  = 8;
  localparam int unsigned LIMIT_W  = 17;
  localparam int unsigned REQ_W    = 3;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 17;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [LIMIT_W-1:0] FRAME_LIMIT_RESET = 17'h10000;

  typedef enum logic [REQ_W-1:0] {
    REQ_FREE  = 3'd0,
    REQ_ALLOC = 3'd1,
    REQ_INC   = 3'd2,
    REQ_DEC   = 3'd3,
    REQ_READ  = 3'd4
  } req_code_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_INVALID   = 3'd2,
    ST_UNDERFLOW = 3'd3,
    ST_OVERFLOW  = 3'd4,
    ST_FULL      = 3'd5
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIRST_VALID = 1'd0,
    REG_FRAME_LIMIT = 1'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_ALLOC
  } state_t;

endpackage

@@ rtl/pfa_if.sv @@
// request, result and configuration channels of the page frame allocator
interface pfa_req_if
  import pfa_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [FRAME_W-1:0] frame_index;

  modport source (output valid, output req_type, output frame_index, input ready);
  modport sink   (input valid, input req_type, input frame_index, output ready);
endinterface

interface pfa_rsp_if
  import pfa_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [FRAME_W-1:0]  frame_out;
  logic [COUNT_W-1:0]  count_out;
  logic                frame_freed;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output frame_out, output count_out, output frame_freed,
                  output status, input ready);
  modport sink   (input valid, input frame_out, input count_out, input frame_freed,
                  input status, output ready);
endinterface

interface pfa_cfg_if
  import pfa_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/page_frame_allocator_refcount_unit.sv @@
// page frame allocator: lifo free stack and per-frame 8-bit reference counts
//
// Manages FRAME_COUNT page frames. Each request word frees a frame (push onto the
// free stack), allocates one (pop), increments, decrements or reads a frame's
// reference count; a decrement that reaches zero pushes the frame back. Frames
// outside [first_valid_frame, frame_limit) or at or above FRAME_COUNT are
// rejected with an invalid status. Both counts and stack live in single-port
// style synchronous memories with registered read. A request passes through an
// accept step with memory read, then a modify and write back step; an allocate
// that finds a frame needs a further step, since the popped frame number must
// come out of the stack memory before its count can be read. One request is in
// flight at a time, but the next one is accepted while the previous result word
// waits in the output register; a request whose result is ready while that
// register is still held stalls in its last cycle until the sink takes the
// waiting word. After reset the count memory is swept to zero, one entry a
// cycle, over all FRAME_COUNT entries, during which no request is accepted;
// configuration writes are taken at any time (cfg ready is always high).
module page_frame_allocator_refcount_unit
  import pfa_pkg::*;
#(
  parameter int unsigned FRAME_COUNT = 65536
) (
  input  logic       clk,
  input  logic       rst,
  pfa_req_if.sink    req,
  pfa_rsp_if.source  rsp,
  pfa_cfg_if.sink    cfg
);

  // memory address and stack depth widths
  localparam int unsigned AW = $clog2(FRAME_COUNT);
  localparam int unsigned DW = $clog2(FRAME_COUNT + 1);
  localparam int unsigned XW = (AW > FRAME_W) ? AW : FRAME_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(FRAME_COUNT - 1);
  localparam logic [DW-1:0] DEPTH_FULL = DW'(FRAME_COUNT);

  // memories
  logic [COUNT_W-1:0] cnt_mem [FRAME_COUNT];
  logic [FRAME_W-1:0] stk_mem [FRAME_COUNT];

  // configuration registers
  logic [FRAME_W-1:0] first_valid;
  logic [LIMIT_W-1:0] frame_limit;

  // control
  state_t state, state_next;
  logic [AW-1:0] clr_addr;
  logic [DW-1:0] depth, depth_next;

  // latched request
  req_code_t r_type;
  logic [FRAME_W-1:0] r_frame;
  logic r_ok;
  logic [FRAME_W-1:0] pop_frame;

  // memory ports
  logic               cnt_rd_en;
  logic [AW-1:0]      cnt_ra;
  logic [COUNT_W-1:0] cnt_rd;
  logic               cnt_we;
  logic [AW-1:0]      cnt_wa;
  logic [COUNT_W-1:0] cnt_wd;
  logic               stk_rd_en;
  logic [FRAME_W-1:0] stk_rd;
  logic               stk_we;

  // output register
  logic               out_valid;
  logic [FRAME_W-1:0] out_frame;
  logic [COUNT_W-1:0] out_count;
  logic               out_freed;
  status_t            out_status;

  logic               emit;
  logic [FRAME_W-1:0] res_frame;
  logic [COUNT_W-1:0] res_count;
  logic               res_freed;
  status_t            res_status;
  logic               pop_latch;

  // address forms of 16-bit frame numbers
  logic [XW-1:0] req_frame_x, pop_frame_x, r_frame_x;
  logic          req_ok;
  logic          can_emit;
  logic          stack_full;

  assign req_frame_x = XW'(req.frame_index);
  assign pop_frame_x = XW'(stk_rd);
  assign r_frame_x   = XW'(r_frame);

  // frame range check on the incoming word
  assign req_ok = (req.frame_index >= first_valid)
               && ({1'b0, req.frame_index} < frame_limit)
               && ({16'd0, req.frame_index} < 32'(FRAME_COUNT));

  assign can_emit   = !out_valid || rsp.ready;
  assign stack_full = (depth >= DEPTH_FULL);
  assign req.ready  = (state == S_IDLE);
  assign cfg.ready  = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      first_valid <= '0;
      frame_limit <= FRAME_LIMIT_RESET;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_FIRST_VALID: first_valid <= cfg.data[FRAME_W-1:0];
        REG_FRAME_LIMIT: frame_limit <= cfg.data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // count memory, registered read
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    if (cnt_rd_en) begin
      cnt_rd <= cnt_mem[cnt_ra];
    end
  end

  // free stack memory, registered read; push goes to the current depth
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[depth[AW-1:0]] <= r_frame;
    end
    if (stk_rd_en) begin
      stk_rd <= stk_mem[AW'(depth - 1'b1)];
    end
  end

  // state, sweep counter and depth
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      depth    <= '0;
    end else begin
      state <= state_next;
      depth <= depth_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  // request latch
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      r_type  <= req_code_t'(req.req_type);
      r_frame <= req.frame_index;
      r_ok    <= req_ok;
    end
    if (pop_latch) begin
      pop_frame <= stk_rd;
    end
  end

  // next state, memory control and result
  always_comb begin
    state_next = state;
    depth_next = depth;
    cnt_rd_en  = 1'b0;
    cnt_ra     = req_frame_x[AW-1:0];
    cnt_we     = 1'b0;
    cnt_wa     = r_frame_x[AW-1:0];
    cnt_wd     = '0;
    stk_rd_en  = 1'b0;
    stk_we     = 1'b0;
    pop_latch  = 1'b0;
    emit       = 1'b0;
    res_frame  = '0;
    res_count  = '0;
    res_freed  = 1'b0;
    res_status = ST_OK;

    case (state)
      S_CLEAR: begin
        // zero sweep of the count memory
        cnt_we = 1'b1;
        cnt_wa = clr_addr;
        if (clr_addr == LAST_ADDR) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (req.valid) begin
          // read the addressed count and the stack top together
          cnt_rd_en  = 1'b1;
          stk_rd_en  = 1'b1;
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        if (r_type == REQ_ALLOC) begin
          if (depth == '0) begin
            if (can_emit) begin
              emit       = 1'b1;
              res_status = ST_EMPTY;
              state_next = S_IDLE;
            end
          end else begin
            // pop, then fetch the popped frame's count
            depth_next = depth - 1'b1;
            pop_latch  = 1'b1;
            cnt_rd_en  = 1'b1;
            cnt_ra     = pop_frame_x[AW-1:0];
            state_next = S_ALLOC;
          end
        end else if (can_emit) begin
          emit       = 1'b1;
          state_next = S_IDLE;
          if (!r_ok) begin
            res_status = ST_INVALID;
          end else begin
            case (r_type)
              REQ_FREE: begin
                if (stack_full) begin
                  res_status = ST_FULL;
                end else begin
                  stk_we     = 1'b1;
                  depth_next = depth + 1'b1;
                  res_count  = cnt_rd;
                end
              end
              REQ_INC: begin
                if (cnt_rd == COUNT_MAX) begin
                  res_status = ST_OVERFLOW;
                end else begin
                  cnt_we    = 1'b1;
                  cnt_wd    = cnt_rd + 1'b1;
                  res_count = cnt_rd + 1'b1;
                end
              end
              REQ_DEC: begin
                if (cnt_rd == '0) begin
                  res_status = ST_UNDERFLOW;
                end else begin
                  cnt_we    = 1'b1;
                  cnt_wd    = cnt_rd - 1'b1;
                  res_count = cnt_rd - 1'b1;
                  // last reference dropped: frame goes back on the stack
                  if (cnt_rd == COUNT_W'(1)) begin
                    if (stack_full) begin
                      res_status = ST_FULL;
                    end else begin
                      stk_we     = 1'b1;
                      depth_next = depth + 1'b1;
                      res_freed  = 1'b1;
                    end
                  end
                end
              end
              REQ_READ: begin
                res_count = cnt_rd;
              end
              default: begin
                // unknown request codes
                res_status = ST_INVALID;
              end
            endcase
          end
        end
      end

      S_ALLOC: begin
        if (can_emit) begin
          emit       = 1'b1;
          res_frame  = pop_frame;
          res_count  = cnt_rd;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_frame  <= res_frame;
      out_count  <= res_count;
      out_freed  <= res_freed;
      out_status <= res_status;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.frame_out   = out_frame;
  assign rsp.count_out   = out_count;
  assign rsp.frame_freed = out_freed;
  assign rsp.status      = out_status;

endmodule

@@ tb/tb_top.sv @@
// self-checking testbench for the page frame allocator with reference counts
module tb_top;
  import pfa_pkg::*;

  localparam int unsigned FRAMES = 65536;
  localparam int unsigned ITEMS_PER_SETTING = 70;
  // upper bound of idle cycles drawn per word on each side
  localparam int unsigned GAP_MAX = 18;

  // one result word as the block hands it out
  typedef struct packed {
    logic [FRAME_W-1:0]  frame;
    logic [COUNT_W-1:0]  count;
    logic                freed;
    status_t             status;
  } result_t;

  // mirror of the free stack and count table; queues the result each request must give
  class refcount_ledger;
    bit [COUNT_W-1:0] counts [FRAMES];
    bit [FRAME_W-1:0] stack [FRAMES];
    int unsigned      depth;
    bit [FRAME_W-1:0] first_frame;
    bit [LIMIT_W-1:0] limit;
    result_t          awaited [$];
    int unsigned      fails;

    function void clear();
      foreach (counts[i]) counts[i] = '0;
      depth = 0;
      first_frame = '0;
      limit = FRAME_LIMIT_RESET;
      awaited.delete();
      fails = 0;
    endfunction

    function void set_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
      if (idx == REG_FIRST_VALID) first_frame = value[FRAME_W-1:0];
      else limit = value[LIMIT_W-1:0];
    endfunction

    function bit push(bit [FRAME_W-1:0] f);
      if (depth >= FRAMES) return 1'b0;
      stack[depth] = f;
      depth++;
      return 1'b1;
    endfunction

    // work out the result word of one accepted request and update the mirror
    function void take_request(logic [REQ_W-1:0] req, logic [FRAME_W-1:0] f);
      result_t          r;
      bit [COUNT_W-1:0] c;
      r = '0;
      r.status = ST_OK;
      if (req == REQ_ALLOC) begin
        if (depth == 0) begin
          r.status = ST_EMPTY;
        end else begin
          depth--;
          r.frame = stack[depth];
          r.count = counts[r.frame];
        end
      end else if (req > REQ_READ) begin
        r.status = ST_INVALID;
      end else if (f < first_frame || {1'b0, f} >= limit) begin
        // a 16-bit frame number is always below the frame count
        r.status = ST_INVALID;
      end else begin
        c = counts[f];
        case (req)
          REQ_FREE: begin
            if (push(f)) r.count = c;
            else r.status = ST_FULL;
          end
          REQ_INC: begin
            if (c == COUNT_MAX) begin
              r.status = ST_OVERFLOW;
            end else begin
              c++;
              counts[f] = c;
              r.count = c;
            end
          end
          REQ_DEC: begin
            if (c == 0) begin
              r.status = ST_UNDERFLOW;
            end else begin
              c--;
              counts[f] = c;
              r.count = c;
              if (c == 0) begin
                if (push(f)) r.freed = 1'b1;
                else r.status = ST_FULL;
              end
            end
          end
          default: r.count = c;
        endcase
      end
      awaited.push_back(r);
    endfunction

    function bit field_check(string name, int unsigned want, int unsigned got);
      if (want == got) return 1'b0;
      $error("%s: expected %0d, got %0d", name, want, got);
      return 1'b1;
    endfunction

    // compare one accepted result word with the oldest expected one
    function void match_result(result_t got);
      result_t want;
      bit      bad;
      if (awaited.size() == 0) begin
        $error("result word with no request outstanding");
        fails++;
        return;
      end
      want = awaited.pop_front();
      bad = field_check("frame_out", want.frame, got.frame);
      bad |= field_check("count_out", want.count, got.count);
      bad |= field_check("frame_freed", want.freed, got.freed);
      bad |= field_check("status", want.status, got.status);
      if (bad) fails++;
    endfunction
  endclass

  logic clk;
  logic rst;

  pfa_req_if req_if ();
  pfa_rsp_if rsp_if ();
  pfa_cfg_if cfg_if ();

  page_frame_allocator_refcount_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if),
    .cfg (cfg_if)
  );

  refcount_ledger ledger = new;

  // frames that get 45 percent of the frame picks of one setting, so counts climb and fall
  logic [FRAME_W-1:0] hot_pool [8];

  always #6 clk = ~clk;

  // safety net well beyond the slowest correct run (clearing sweep included)
  initial begin
    #30000000;
    $display("page_frame_allocator_refcount_unit test failed");
    $finish;
  end

  // result side: random stall before each word, then hold ready until the word arrives
  initial begin : result_sink
    int unsigned stall;
    rsp_if.ready = 1'b0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      stall = $urandom_range(0, GAP_MAX);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!rsp_if.valid);
      ledger.match_result('{frame: rsp_if.frame_out, count: rsp_if.count_out,
                            freed: rsp_if.frame_freed, status: status_t'(rsp_if.status)});
    end
  end

  // offer one request word after a random gap; valid stays high for a following word
  task automatic send_req(logic [REQ_W-1:0] kind, logic [FRAME_W-1:0] frame);
    int unsigned gap;
    gap = $urandom_range(0, GAP_MAX);
    @(negedge clk);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.req_type    <= kind;
    req_if.frame_index <= frame;
    do @(posedge clk); while (!req_if.ready);
    ledger.take_request(kind, frame);
  endtask

  task automatic req_stop();
    @(negedge clk);
    req_if.valid <= 1'b0;
  endtask

  task automatic wait_drain();
    while (ledger.awaited.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    ledger.set_register(idx, value);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // reprogram the valid range with the block idle
  task automatic set_range(logic [FRAME_W-1:0] first, logic [LIMIT_W-1:0] limit);
    req_stop();
    wait_drain();
    write_reg(REG_FIRST_VALID, CFG_DATA_W'(first));
    write_reg(REG_FRAME_LIMIT, CFG_DATA_W'(limit));
  endtask

  // random traffic under one range setting
  task automatic run_setting(logic [FRAME_W-1:0] first, logic [LIMIT_W-1:0] limit);
    int                 span;
    int unsigned        pick;
    logic [REQ_W-1:0]   kind;
    logic [FRAME_W-1:0] frame;
    set_range(first, limit);
    span = int'(limit) - int'(first);
    foreach (hot_pool[i]) begin
      if (span > 0) hot_pool[i] = FRAME_W'(int'(first) + $urandom_range(0, span - 1));
      else hot_pool[i] = FRAME_W'($urandom);
    end
    if (span > 0) begin
      hot_pool[0] = first;
      hot_pool[1] = FRAME_W'(limit - 1);
    end
    for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 18) kind = REQ_FREE;
      else if (pick < 36) kind = REQ_ALLOC;
      else if (pick < 62) kind = REQ_INC;
      else if (pick < 84) kind = REQ_DEC;
      else if (pick < 94) kind = REQ_READ;
      else kind = REQ_W'(REQ_READ + $urandom_range(1, 3));   // undefined request codes
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        frame = hot_pool[$urandom_range(0, 7)];
      end else if (pick < 65) begin
        // just around both ends of the range
        case ($urandom_range(0, 3))
          0: frame = first - 1'b1;
          1: frame = first;
          2: frame = FRAME_W'(limit - 1);
          default: frame = limit[FRAME_W-1:0];
        endcase
      end else begin
        frame = FRAME_W'($urandom);
      end
      send_req(kind, frame);
      // now and then hold off until every outstanding result word is back
      if ($urandom_range(0, 99) == 0) begin
        req_stop();
        wait_drain();
      end
    end
  endtask

  initial begin : stimulus
    logic [FRAME_W-1:0] probe;
    clk = 1'b0;
    rst = 1'b1;
    req_if.valid       = 1'b0;
    req_if.req_type    = REQ_FREE;
    req_if.frame_index = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_FIRST_VALID;
    cfg_if.data  = '0;
    ledger.clear();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: range 2..65533, edges of the range and every request kind
    set_range(16'd2, 17'd65534);
    send_req(REQ_ALLOC, 16'hffff);     // empty stack
    send_req(REQ_READ, 16'h0000);      // below first valid frame
    send_req(REQ_READ, 16'hffff);      // beyond the limit
    send_req(REQ_READ, 16'd65534);     // exactly at the limit
    send_req(REQ_READ, 16'd1);
    send_req(REQ_INC, 16'd2);
    send_req(REQ_DEC, 16'd2);          // reaches zero, frame goes back on the stack
    send_req(REQ_DEC, 16'd2);          // decrement at zero
    send_req(REQ_READ, 16'd2);
    send_req(REQ_ALLOC, 16'h0000);
    send_req(REQ_FREE, 16'd65533);
    send_req(REQ_INC, 16'd65533);
    send_req(REQ_ALLOC, 16'h5555);     // popped frame reports its nonzero count
    send_req(REQ_ALLOC, 16'haaaa);
    send_req(REQ_FREE, 16'h0000);      // free outside the range
    send_req(REQ_W'(REQ_READ + 1), 16'hffff);
    send_req(REQ_W'(REQ_READ + 2), 16'd2);
    send_req(REQ_W'(REQ_READ + 3), 16'h0000);
    send_req(REQ_FREE, 16'd2);
    send_req(REQ_FREE, 16'd3);
    send_req(REQ_ALLOC, 16'h0000);
    send_req(REQ_READ, 16'd65533);

    // count saturation and the walk all the way back down on one frame
    repeat (256) send_req(REQ_INC, 16'd3);
    send_req(REQ_READ, 16'd3);
    repeat (255) send_req(REQ_DEC, 16'd3);
    send_req(REQ_READ, 16'd3);

    // random traffic over several range settings, the extremes among them
    run_setting(16'd0, FRAME_LIMIT_RESET);
    run_setting(FRAME_W'($urandom_range(1, 16'hff00)), '0);
    begin
      probe = FRAME_W'($urandom_range(1, 16'hff00));
      run_setting(probe, LIMIT_W'(probe) + LIMIT_W'($urandom_range(1, 40)));
    end
    run_setting(16'hffff, FRAME_LIMIT_RESET);
    begin
      probe = FRAME_W'($urandom_range(200, 60000));
      run_setting(probe, LIMIT_W'(probe) - LIMIT_W'($urandom_range(1, 100)));
    end
    run_setting(16'd0, 17'd1);
    run_setting(FRAME_W'($urandom_range(0, 16'h3fff)),
                LIMIT_W'($urandom_range(16'h8000, 17'h1ffff)));

    // let the last words come back, then a few quiet cycles for stray output
    req_stop();
    wait_drain();
    repeat (16) @(posedge clk);
    if (ledger.fails == 0 && ledger.awaited.size() == 0) begin
      $display("page_frame_allocator_refcount_unit test passed");
    end else begin
      $display("page_frame_allocator_refcount_unit test failed");
    end
    $finish;
  end

endmodule

@@ page_frame_allocator_refcount_unit.f @@
rtl/pfa_pkg.sv
rtl/pfa_if.sv
rtl/page_frame_allocator_refcount_unit.sv
tb/tb_top.sv
